// ----- src/contiguous_block_allocator_top_macros.svh -----
// Assertion macros for the verification checker of the allocator.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CBA_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("contiguous block allocator check failed");

// The consequent must hold in the cycle after the antecedent.
`define CBA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("contiguous block allocator check failed");

`endif

// ----- src/cba_pkg.sv -----
package cba_pkg;

   // Operation codes of the cmd field.
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // Width of the size field.
   localparam int SIZE_W = 5;

   // Per-block status marks.
   typedef enum logic [2:0] {
      MARK_FREE   = 3'd0,
      MARK_SINGLE = 3'd1,
      MARK_FIRST  = 3'd2,
      MARK_MIDDLE = 3'd3,
      MARK_LAST   = 3'd4
   } mark_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_SPACE  = 2'd1,
      ST_BAD_SIZE  = 2'd2,
      ST_NOT_START = 2'd3
   } status_type;

   typedef struct packed {
      logic              cmd;
      logic [SIZE_W-1:0] req_size;
      logic [3:0]        start_index;
   } req_type;

   typedef struct packed {
      status_type status_code;
      logic [3:0] alloc_index;
      logic       was_free;
   } rsp_type;

   // Write request from the sequencer to the status map.
   typedef struct packed {
      logic     en;
      mark_type mark;
   } map_wr_type;

endpackage

// ----- src/cba_map.sv -----
module cba_map #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [$clog2(NUM_BLOCKS)-1:0] raddr,
   input  logic [$clog2(NUM_BLOCKS)-1:0] waddr,
   input  cba_pkg::map_wr_type           wr,
   output cba_pkg::mark_type             rmark
);
   import cba_pkg::*;

   mark_type              mem_ff [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0] valid_ff;
   mark_type              rdata_ff;
   logic                  rvalid_ff;

   // Status storage; contents are only meaningful where the valid bit is set.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[waddr] <= wr.mark;
      end
      rdata_ff  <= mem_ff[raddr];
      rvalid_ff <= valid_ff[raddr];
   end

   // Valid bits make the whole map read as free right after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   assign rmark = rvalid_ff ? rdata_ff : MARK_FREE;

endmodule

// ----- src/cba_ctrl.sv -----
module cba_ctrl #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  cba_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output cba_pkg::rsp_type              rsp_data,
   output logic [$clog2(NUM_BLOCKS)-1:0] map_raddr,
   output logic [$clog2(NUM_BLOCKS)-1:0] map_waddr,
   output cba_pkg::map_wr_type           map_wr,
   input  cba_pkg::mark_type             map_rmark
);
   import cba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);
   localparam int CW = $clog2(NUM_BLOCKS + 1);
   localparam int XW = (CW > SIZE_W) ? CW : SIZE_W;
   localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BLOCKS - 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_MARK  = 6'b000100,
      S_FCHK  = 6'b001000,
      S_FWALK = 6'b010000,
      S_RESP  = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [AW-1:0]     begin_ff, begin_in;
   logic [AW-1:0]     end_ff, end_in;
   logic [CW-1:0]     run_ff, run_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   rsp_type           rsp_ff, rsp_in;
   logic              accept;
   logic              idx_last;
   logic [AW-1:0]     idx_next;
   logic [CW-1:0]     run_inc;
   logic [AW-1:0]     run_begin;
   logic              size_bad;
   logic              start_bad;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;

   assign idx_last  = (idx_ff == LAST_IDX);
   assign idx_next  = idx_last ? '0 : idx_ff + 1'b1;
   assign run_inc   = run_ff + 1'b1;
   assign run_begin = (run_ff == '0) ? idx_ff : begin_ff;
   assign size_bad  = (req_data.req_size == '0) ||
                      (XW'(req_data.req_size) > XW'(NUM_BLOCKS));
   assign start_bad = (32'(req_data.start_index) >= 32'(NUM_BLOCKS));

   // Sequencer: during a scan, mark or free walk, one map entry is read, checked or written per cycle.
   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      begin_in   = begin_ff;
      end_in     = end_ff;
      run_in     = run_ff;
      size_in    = size_ff;
      rsp_in     = rsp_ff;
      map_raddr  = idx_next;
      map_waddr  = idx_ff;
      map_wr.en   = 1'b0;
      map_wr.mark = MARK_FREE;
      case (state_ff)
         S_IDLE: begin
            map_raddr = (req_data.cmd == CMD_ALLOC) ? '0 : AW'(req_data.start_index);
            if (accept) begin
               rsp_in.status_code = ST_OK;
               rsp_in.alloc_index = '0;
               rsp_in.was_free    = 1'b0;
               size_in = req_data.req_size;
               run_in  = '0;
               if (req_data.cmd == CMD_ALLOC) begin
                  idx_in = '0;
                  if (size_bad) begin
                     rsp_in.status_code = ST_BAD_SIZE;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else begin
                  idx_in = AW'(req_data.start_index);
                  if (start_bad) begin
                     rsp_in.status_code = ST_NOT_START;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_FCHK;
                  end
               end
            end
         end
         S_SCAN: begin
            // First-fit scan: count consecutive free entries.
            if (map_rmark == MARK_FREE) begin
               run_in   = run_inc;
               begin_in = run_begin;
               if (XW'(run_inc) == XW'(size_ff)) begin
                  end_in   = idx_ff;
                  idx_in   = run_begin;
                  state_in = S_MARK;
               end else if (idx_last) begin
                  rsp_in.status_code = ST_NO_SPACE;
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_next;
               end
            end else begin
               run_in = '0;
               if (idx_last) begin
                  rsp_in.status_code = ST_NO_SPACE;
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_next;
               end
            end
         end
         S_MARK: begin
            // Write the run marks from its start to its end.
            map_wr.en = 1'b1;
            if (size_ff == SIZE_W'(1)) begin
               map_wr.mark = MARK_SINGLE;
            end else if (idx_ff == begin_ff) begin
               map_wr.mark = MARK_FIRST;
            end else if (idx_ff == end_ff) begin
               map_wr.mark = MARK_LAST;
            end else begin
               map_wr.mark = MARK_MIDDLE;
            end
            if (idx_ff == end_ff) begin
               rsp_in.status_code = ST_OK;
               rsp_in.alloc_index = 4'(begin_ff);
               state_in = S_RESP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_FCHK: begin
            // Only a single or first mark may start a free.
            if (map_rmark == MARK_FREE) begin
               rsp_in.status_code = ST_NOT_START;
               rsp_in.was_free    = 1'b1;
               state_in = S_RESP;
            end else if (map_rmark != MARK_SINGLE && map_rmark != MARK_FIRST) begin
               rsp_in.status_code = ST_NOT_START;
               state_in = S_RESP;
            end else begin
               map_wr.en = 1'b1;
               rsp_in.status_code = ST_OK;
               if (map_rmark == MARK_SINGLE || idx_last) begin
                  state_in = S_RESP;
               end else begin
                  idx_in   = idx_next;
                  state_in = S_FWALK;
               end
            end
         end
         S_FWALK: begin
            // Clear middle marks, then a last mark, and stop on anything else.
            if (map_rmark == MARK_MIDDLE) begin
               map_wr.en = 1'b1;
               if (idx_last) begin
                  state_in = S_RESP;
               end else begin
                  idx_in = idx_next;
               end
            end else begin
               map_wr.en = (map_rmark == MARK_LAST);
               state_in  = S_RESP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Working registers and the result transaction.
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      begin_ff <= begin_in;
      end_ff   <= end_in;
      run_ff   <= run_in;
      size_ff  <= size_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ----- src/contiguous_block_allocator_top.sv -----
// Allocate: a first-fit scan of the map, then the marking of the run if one fits, then the result.
// Free: a check of the start entry, then a walk over the entries past the start, then the result.
// Rejected sizes or indexes give a result in the cycle after acceptance.
// One transaction at a time; the status map delivers one entry per cycle.
// Reset (synchronous) returns to idle and makes every block read as free at once.
module contiguous_block_allocator_top #(
   parameter int NUM_BLOCKS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cba_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cba_pkg::rsp_type rsp_data
);
   import cba_pkg::*;

   localparam int AW = $clog2(NUM_BLOCKS);

   logic [AW-1:0] map_raddr;
   logic [AW-1:0] map_waddr;
   map_wr_type    map_wr;
   mark_type      map_rmark;

   // Sequencer driving the scan, mark and free walks.
   cba_ctrl #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .map_raddr (map_raddr),
      .map_waddr (map_waddr),
      .map_wr    (map_wr),
      .map_rmark (map_rmark)
   );

   // Block status map.
   cba_map #(
      .NUM_BLOCKS(NUM_BLOCKS)
   ) u_map (
      .clock (clock),
      .reset (reset),
      .raddr (map_raddr),
      .waddr (map_waddr),
      .wr    (map_wr),
      .rmark (map_rmark)
   );

endmodule

// ----- src/cba_checker.sv -----
`include "contiguous_block_allocator_top_macros.svh"

module cba_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cba_pkg::rsp_type rsp_data
);
   import cba_pkg::*;

   // A stalled result transaction holds.
   `CBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // An accepted transaction keeps the block busy.
   `CBA_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // No new transaction is taken while a result is pending.
   `CBA_ASSERT_SAME(a_stall_on_rsp, rsp_valid, req_stall)

   // Only a refused free reports an already-free block.
   `CBA_ASSERT_SAME(a_was_free_code, rsp_valid && rsp_data.was_free,
                    rsp_data.status_code == ST_NOT_START)

   // A start index is reported only by a successful allocate.
   `CBA_ASSERT_SAME(a_index_on_ok, rsp_valid && rsp_data.status_code != ST_OK,
                    rsp_data.alloc_index == 4'd0)

endmodule

bind contiguous_block_allocator_top cba_checker u_cba_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
